/* rtl/fraction_reduce_lowest_terms_assert.svh */
`ifndef FRACTION_REDUCE_LOWEST_TERMS_ASSERT_SVH
`define FRACTION_REDUCE_LOWEST_TERMS_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define FRLT_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("frlt check failed");

// check a condition in the cycle after its trigger
`define FRLT_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("frlt check failed");

`endif

/* rtl/frlt_pkg.sv */
package frlt_pkg;

    localparam int WIDTH = 16;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_frlt_cmd;

    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_frlt_sts;

endpackage

/* rtl/frlt_in_if.sv */
interface frlt_in_if import frlt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] num_in;
    logic signed [WIDTH-1:0] den_in;

    modport source (output valid, output num_in, output den_in, input ready);
    modport sink (input valid, input num_in, input den_in, output ready);
endinterface

/* rtl/frlt_out_if.sv */
interface frlt_out_if import frlt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] num_out;
    logic signed [WIDTH-1:0] den_out;
    logic                    den_zero_error;

    modport source (output valid, output num_out, output den_out, output den_zero_error,
                    input ready);
    modport sink (input valid, input num_out, input den_out, input den_zero_error,
                  output ready);
endinterface

/* rtl/frlt_ctrl.sv */
module frlt_ctrl import frlt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_frlt_sts i_sts,
    output t_frlt_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GCD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.special) begin
                    n_state = S_DONE;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

endmodule

/* rtl/frlt_dp.sv */
module frlt_dp import frlt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_frlt_cmd               i_cmd,
    output t_frlt_sts               o_sts,
    input  logic signed [WIDTH-1:0] i_num,
    input  logic signed [WIDTH-1:0] i_den,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [WIDTH-1:0] o_num,
    output logic signed [WIDTH-1:0] o_den,
    output logic                    o_den_zero_error
);

    `include "fraction_reduce_lowest_terms_assert.svh"

    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_amag;
    logic [WIDTH-1:0] r_bmag;
    logic [WIDTH-1:0] r_g;
    logic [WIDTH-1:0] r_qa;
    logic [WIDTH-1:0] r_qb;
    logic [WIDTH-1:0] r_ra;
    logic [WIDTH-1:0] r_rb;
    logic [CNT_W-1:0] r_cnt;
    logic             r_nneg;
    logic             r_dneg;
    logic             r_nzero;
    logic             r_dzero;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_num_out;
    logic [WIDTH-1:0] r_den_out;
    logic             r_err_out;

    logic [WIDTH-1:0] w_num_mag;
    logic [WIDTH-1:0] w_den_mag;
    logic [WIDTH:0]   w_ta;
    logic [WIDTH:0]   w_tb;
    logic [WIDTH:0]   w_da;
    logic [WIDTH:0]   w_db;
    logic [WIDTH-1:0] w_num_res;
    logic [WIDTH-1:0] w_den_res;

    assign w_num_mag = i_num[WIDTH-1] ? (~i_num) + WIDTH'(1) : i_num;
    assign w_den_mag = i_den[WIDTH-1] ? (~i_den) + WIDTH'(1) : i_den;

    assign w_ta = {r_ra, r_qa[WIDTH-1]};
    assign w_tb = {r_rb, r_qb[WIDTH-1]};
    assign w_da = w_ta - {1'b0, r_g};
    assign w_db = w_tb - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= w_num_mag;
            r_b     <= w_den_mag;
            r_amag  <= w_num_mag;
            r_bmag  <= w_den_mag;
            r_nneg  <= i_num[WIDTH-1];
            r_dneg  <= i_den[WIDTH-1];
            r_nzero <= (i_num == '0);
            r_dzero <= (i_den == '0);
        end else if (i_cmd.gcd_step) begin
            if (r_a > r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_a;
            r_qa  <= r_amag;
            r_qb  <= r_bmag;
            r_ra  <= '0;
            r_rb  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_da[WIDTH]) begin
                r_ra <= w_da[WIDTH-1:0];
                r_qa <= {r_qa[WIDTH-2:0], 1'b1};
            end else begin
                r_ra <= w_ta[WIDTH-1:0];
                r_qa <= {r_qa[WIDTH-2:0], 1'b0};
            end
            if (!w_db[WIDTH]) begin
                r_rb <= w_db[WIDTH-1:0];
                r_qb <= {r_qb[WIDTH-2:0], 1'b1};
            end else begin
                r_rb <= w_tb[WIDTH-1:0];
                r_qb <= {r_qb[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign w_num_res = r_nneg ? (~r_qa) + WIDTH'(1) : r_qa;
    assign w_den_res = r_dneg ? (~r_qb) + WIDTH'(1) : r_qb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_dzero) begin
                r_num_out <= '0;
                r_den_out <= '0;
                r_err_out <= 1'b1;
            end else if (r_nzero) begin
                r_num_out <= '0;
                r_den_out <= WIDTH'(1);
                r_err_out <= 1'b0;
            end else begin
                r_num_out <= w_num_res;
                r_den_out <= w_den_res;
                r_err_out <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.special  = r_nzero | r_dzero;
    assign o_sts.gcd_done = (r_a == r_b);
    assign o_sts.div_done = (r_cnt == CNT_W'(WIDTH - 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid          = r_out_valid;
    assign o_num            = r_num_out;
    assign o_den            = r_den_out;
    assign o_den_zero_error = r_err_out;

    `FRLT_ASSERT_NEXT(a_gcd_nonzero, i_cmd.gcd_step, (r_a != '0) && (r_b != '0))
    `FRLT_ASSERT_NOW(a_div_after_gcd, i_cmd.div_init, (r_a == r_b) && !o_sts.special)
    `FRLT_ASSERT_NOW(a_rem_below_div, i_cmd.div_step, (r_ra < r_g) && (r_rb < r_g))
    `FRLT_ASSERT_NOW(a_out_no_overrun, i_cmd.out_load, !r_out_valid || i_ready)

endmodule

/* rtl/fraction_reduce_lowest_terms.sv */
// Reduces a signed fraction num_in/den_in to lowest terms, keeping each member's sign
// as given. One fraction is worked on at a time: a transaction is taken only while the
// block is idle, and the result waits in an output register, so the next fraction is
// taken while the previous result is still pending. A fraction is loaded, then run
// through the subtractive GCD loop and the restoring divider that divides both
// magnitudes by the GCD in parallel, and is written to the output register once that
// register is free. A zero numerator (0/1) or zero denominator (0/0 with den_zero_error
// set) skips the GCD and divider.
module fraction_reduce_lowest_terms import frlt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    frlt_in_if.sink    i_in,
    frlt_out_if.source o_out
);

    t_frlt_cmd w_cmd;
    t_frlt_sts w_sts;

    frlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    frlt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_num            (i_in.num_in),
        .i_den            (i_in.den_in),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_num            (o_out.num_out),
        .o_den            (o_out.den_out),
        .o_den_zero_error (o_out.den_zero_error)
    );

endmodule
